// ===== design/binary_image_thinning_top_macros.svh =====
// assertion macros used by the thinning block checker
`ifndef BINARY_IMAGE_THINNING_TOP_MACROS_SVH
`define BINARY_IMAGE_THINNING_TOP_MACROS_SVH

// condition holds in the same cycle as its trigger
`define BTHIN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bthin check failed");

// condition holds in the cycle after its trigger
`define BTHIN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bthin check failed");

`endif

// ===== design/bthin_pkg.sv =====
// shared constants, types and helper functions of the thinning block
package bthin_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 12;
  localparam int ITER_W     = 8;
  localparam int CFG_DIM_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // width able to hold any region size, and signed neighbor coordinates
  localparam int MAXW_W = $clog2(MAX_WIDTH + 1);
  localparam int MAXH_W = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_A  = (MAXW_W > MAXH_W) ? MAXW_W : MAXH_W;
  localparam int DIM_W  = (DIM_A > CFG_DIM_W) ? DIM_A : CFG_DIM_W;
  localparam int NB_W   = DIM_W + 1;

  // neighbor walk: center then ring p2..p9
  localparam int K_W = 4;
  localparam logic [K_W-1:0] K_LAST = K_W'(8);

  localparam logic [ITER_W-1:0] ITER_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VAL = 2'd3;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_capture;
    logic run_start;
    logic limit_set;
    logic iter_begin;
    logic scan_second;
    logic nb_issue;
    logic nb_capture;
    logic eval;
    logic clr_start;
    logic clr_issue;
    logic clr_apply;
    logic next_pix;
    logic out_load;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic limit_reached;
    logic region_empty;
    logic k_last;
    logic pix_last;
    logic marked_any;
    logic second;
    logic out_free;
  } sts_t;

  // row offset of neighbor k
  function automatic logic signed [1:0] nb_dr(input logic [K_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      4'd1, 4'd2, 4'd8: d = -2'sd1;
      4'd4, 4'd5, 4'd6: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // column offset of neighbor k
  function automatic logic signed [1:0] nb_dc(input logic [K_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      4'd2, 4'd3, 4'd4: d = 2'sd1;
      4'd6, 4'd7, 4'd8: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/binary_image_thinning_top.sv =====
// top level of the zhang-suen thinning block
// Write and read commands touch one pixel of the 64x64 image store; a read passes
// through a read-wait state before its result is loaded. A run command thins the
// region in place: each sub-pass fetches the nine pixels of each window through
// the single read port of the image store, decides and writes the mark, and then
// clears the marked pixels in a clear pass; one iteration is two such sub-passes
// plus control. A new command is taken once the current one has finished; a
// finished result waits in an output register without holding up the next command.
module binary_image_thinning_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bthin_pkg::CMD_W-1:0]      in_command_i,
  input  logic [bthin_pkg::IDX_W-1:0]      in_pixel_index_i,
  input  logic                             in_pixel_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_read_value_o,
  output logic [bthin_pkg::ITER_W-1:0]     out_iterations_used_o,
  output logic                             out_stopped_by_limit_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bthin_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bthin_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bthin_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  bthin_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_command_i),
    .in_stall_o   (in_stall_o),
    .sts_i        (sts),
    .ctl_o        (ctl)
  );

  // stores and pixel logic
  bthin_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_command_i           (in_command_i),
    .in_pixel_index_i       (in_pixel_index_i),
    .in_pixel_value_i       (in_pixel_value_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .out_stall_i            (out_stall_i),
    .out_valid_o            (out_valid_o),
    .out_read_value_o       (out_read_value_o),
    .out_iterations_used_o  (out_iterations_used_o),
    .out_stopped_by_limit_o (out_stopped_by_limit_o),
    .ctl_i                  (ctl),
    .sts_o                  (sts)
  );

endmodule

// ===== design/bthin_ram.sv =====
// generic single write, single read ram with registered read data
module bthin_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bthin_ctrl.sv =====
// controller state machine sequencing commands, scans and clear passes
module bthin_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [bthin_pkg::CMD_W-1:0] in_command_i,
  output logic                        in_stall_o,
  input  bthin_pkg::sts_t             sts_i,
  output bthin_pkg::ctl_t             ctl_o
);
  import bthin_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_RD_WAIT = 10'b0000000010,
    ST_CHECK   = 10'b0000000100,
    ST_NB_ADDR = 10'b0000001000,
    ST_NB_DATA = 10'b0000010000,
    ST_EVAL    = 10'b0000100000,
    ST_CL_ADDR = 10'b0001000000,
    ST_CL_DATA = 10'b0010000000,
    ST_PASS    = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          case (cmd_e'(in_command_i))
            CMD_READ: state_d = ST_RD_WAIT;
            CMD_RUN: begin
              ctl_o.run_start = 1'b1;
              state_d         = ST_CHECK;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RD_WAIT: begin
        ctl_o.rd_capture = 1'b1;
        state_d          = ST_DONE;
      end
      ST_CHECK: begin
        if (sts_i.limit_reached) begin
          ctl_o.limit_set = 1'b1;
          state_d         = ST_DONE;
        end else begin
          ctl_o.iter_begin = 1'b1;
          state_d          = sts_i.region_empty ? ST_DONE : ST_NB_ADDR;
        end
      end
      ST_NB_ADDR: begin
        ctl_o.nb_issue = 1'b1;
        state_d        = ST_NB_DATA;
      end
      ST_NB_DATA: begin
        ctl_o.nb_capture = 1'b1;
        state_d          = sts_i.k_last ? ST_EVAL : ST_NB_ADDR;
      end
      ST_EVAL: begin
        ctl_o.eval = 1'b1;
        if (sts_i.pix_last) begin
          ctl_o.clr_start = 1'b1;
          state_d         = ST_CL_ADDR;
        end else begin
          ctl_o.next_pix = 1'b1;
          state_d        = ST_NB_ADDR;
        end
      end
      ST_CL_ADDR: begin
        ctl_o.clr_issue = 1'b1;
        state_d         = ST_CL_DATA;
      end
      ST_CL_DATA: begin
        ctl_o.clr_apply = 1'b1;
        if (sts_i.pix_last) begin
          state_d = ST_PASS;
        end else begin
          ctl_o.next_pix = 1'b1;
          state_d        = ST_CL_ADDR;
        end
      end
      ST_PASS: begin
        if (!sts_i.marked_any) begin
          state_d = ST_DONE;
        end else if (!sts_i.second) begin
          ctl_o.scan_second = 1'b1;
          state_d           = ST_NB_ADDR;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/bthin_dp.sv =====
// datapath: image and mark stores, scan counters, pixel test, result register
module bthin_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bthin_pkg::CMD_W-1:0]      in_command_i,
  input  logic [bthin_pkg::IDX_W-1:0]      in_pixel_index_i,
  input  logic                             in_pixel_value_i,
  input  logic                             cfg_valid_i,
  input  logic [bthin_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bthin_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic                             out_read_value_o,
  output logic [bthin_pkg::ITER_W-1:0]     out_iterations_used_o,
  output logic                             out_stopped_by_limit_o,
  input  bthin_pkg::ctl_t                  ctl_i,
  output bthin_pkg::sts_t                  sts_o
);
  import bthin_pkg::*;

  // configuration registers
  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic                 limit_en_q;
  logic [ITER_W-1:0]    limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DIM_RESET;
      height_q   <= DIM_RESET;
      limit_en_q <= 1'b0;
      limit_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:     width_q    <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_HEIGHT:    height_q   <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_LIMIT_EN:  limit_en_q <= cfg_data_i[0];
        CFG_LIMIT_VAL: limit_q    <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // region clamped to the store size
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_q);
  assign h_eff = (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                          : DIM_W'(height_q);

  // scan position, neighbor counter and pass state
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [K_W-1:0]   k_q;
  logic             second_q, marked_q;
  logic [ITER_W-1:0] iter_q;
  logic             limit_hit_q;
  logic             col_last, row_last;

  assign col_last = (DIM_W'(col_q) + DIM_W'(1)) == w_eff;
  assign row_last = (DIM_W'(row_q) + DIM_W'(1)) == h_eff;

  logic mark;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      second_q    <= 1'b0;
      marked_q    <= 1'b0;
      iter_q      <= '0;
      limit_hit_q <= 1'b0;
    end else begin
      if (ctl_i.run_start) begin
        iter_q      <= '0;
        limit_hit_q <= 1'b0;
      end
      if (ctl_i.limit_set) begin
        limit_hit_q <= 1'b1;
      end
      if (ctl_i.iter_begin || ctl_i.scan_second) begin
        row_q    <= '0;
        col_q    <= '0;
        k_q      <= '0;
        marked_q <= 1'b0;
        second_q <= ctl_i.scan_second;
      end
      if (ctl_i.iter_begin && (iter_q != ITER_MAX)) begin
        iter_q <= iter_q + ITER_W'(1);
      end
      if (ctl_i.nb_capture) begin
        k_q <= k_q + K_W'(1);
      end
      if (ctl_i.eval) begin
        k_q      <= '0;
        marked_q <= marked_q | mark;
      end
      if (ctl_i.clr_start) begin
        row_q <= '0;
        col_q <= '0;
      end
      if (ctl_i.next_pix) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // neighbor coordinates and region test
  logic signed [NB_W-1:0] nr, nc;
  logic                   nb_inreg;
  logic [ADDR_W-1:0]      nb_addr, ctr_addr;

  assign nr = $signed(NB_W'(row_q)) + NB_W'(nb_dr(k_q));
  assign nc = $signed(NB_W'(col_q)) + NB_W'(nb_dc(k_q));
  assign nb_inreg = !nr[NB_W-1] && !nc[NB_W-1] &&
                    (nr < $signed(NB_W'(h_eff))) && (nc < $signed(NB_W'(w_eff)));
  assign nb_addr  = ADDR_W'(nr[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nc[COL_W-1:0]);
  assign ctr_addr = ADDR_W'(row_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_q);

  // command decode at transfer
  logic in_range;
  logic in_write;
  assign in_range = 32'(in_pixel_index_i) < 32'(DEPTH);
  assign in_write = ctl_i.accept && (cmd_e'(in_command_i) == CMD_WRITE) && in_range;

  // image store ports
  logic              st_we, st_wdata, st_re, st_rdata;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic              mk_rdata;

  assign st_we    = in_write || (ctl_i.clr_apply && mk_rdata);
  assign st_waddr = in_write ? ADDR_W'(in_pixel_index_i) : ctr_addr;
  assign st_wdata = in_write ? in_pixel_value_i : 1'b0;
  assign st_re    = ctl_i.accept || ctl_i.nb_issue;
  assign st_raddr = ctl_i.accept ? ADDR_W'(in_pixel_index_i) : nb_addr;

  bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_image (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // delete mark store, rewritten for every region pixel in each scan
  bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
    .clk_i   (clk_i),
    .we_i    (ctl_i.eval),
    .waddr_i (ctr_addr),
    .wdata_i (mark),
    .re_i    (ctl_i.clr_issue),
    .raddr_i (ctr_addr),
    .rdata_o (mk_rdata)
  );

  // neighbor window capture
  logic [8:0] p_q;
  logic       inreg_q, range_q, read_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.nb_issue) begin
      inreg_q <= nb_inreg;
    end
    if (ctl_i.nb_capture) begin
      p_q[k_q] <= st_rdata & inreg_q;
    end
    if (ctl_i.accept) begin
      range_q <= in_range;
      read_q  <= 1'b0;
    end
    if (ctl_i.rd_capture) begin
      read_q <= st_rdata & range_q;
    end
  end

  // pixel test
  logic [7:0] ring;
  logic [3:0] n_cnt;
  logic [3:0] t_cnt;
  logic       prod_hit;

  assign ring  = p_q[8:1];
  assign n_cnt = 4'($countones(ring));

  always_comb begin
    t_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      t_cnt = t_cnt + 4'(!ring[i] && ring[(i + 1) % 8]);
    end
  end

  assign prod_hit = second_q ? ((ring[0] & ring[2] & ring[6]) | (ring[0] & ring[4] & ring[6]))
                             : ((ring[0] & ring[2] & ring[4]) | (ring[2] & ring[4] & ring[6]));
  assign mark = p_q[0] && (n_cnt >= 4'd2) && (n_cnt <= 4'd6) && (t_cnt == 4'd1) && !prod_hit;

  // result register
  logic              out_valid_q, out_read_q, out_lim_q;
  logic [ITER_W-1:0] out_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_read_q <= read_q;
      out_iter_q <= iter_q;
      out_lim_q  <= limit_hit_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_read_value_o       = out_read_q;
  assign out_iterations_used_o  = out_iter_q;
  assign out_stopped_by_limit_o = out_lim_q;

  // status to controller
  assign sts_o.limit_reached = limit_en_q && (iter_q >= limit_q);
  assign sts_o.region_empty  = (w_eff == '0) || (h_eff == '0);
  assign sts_o.k_last        = (k_q == K_LAST);
  assign sts_o.pix_last      = col_last && row_last;
  assign sts_o.marked_any    = marked_q;
  assign sts_o.second        = second_q;
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;

endmodule

// ===== design/bthin_chk.sv =====
// port level checker for the thinning block and its bind
`include "binary_image_thinning_top_macros.svh"

module bthin_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         out_read_value_o,
  input logic [bthin_pkg::ITER_W-1:0] out_iterations_used_o,
  input logic                         out_stopped_by_limit_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);

  // result payload as one vector
  logic [bthin_pkg::ITER_W+1:0] out_payload;
  assign out_payload = {out_read_value_o, out_iterations_used_o, out_stopped_by_limit_o};

  // a stalled result stays offered
  `BTHIN_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `BTHIN_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_payload))

  // one command at a time: busy right after a transfer
  `BTHIN_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o)

  // configuration writes never wait
  `BTHIN_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind binary_image_thinning_top bthin_chk u_bthin_chk (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_valid_i),
  .in_stall_o             (in_stall_o),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .out_read_value_o       (out_read_value_o),
  .out_iterations_used_o  (out_iterations_used_o),
  .out_stopped_by_limit_o (out_stopped_by_limit_o),
  .cfg_valid_i            (cfg_valid_i),
  .cfg_ready_o            (cfg_ready_o)
);
